[hw/rtl/md5_pkg.sv]
// md5_pkg: shared constants, round tables and helper functions for the MD5 engine.
// No dependencies; used by md5_round_unit and md5_hash_engine.

package md5_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int ADDR_W      = 4;
  localparam int ROUNDS      = 64;
  localparam int CNT_W       = 7;
  localparam int LEN_WORD    = 14;   // position of the low length word in the final block
  localparam int PAD_LIMIT   = 56;   // bytes that fit ahead of the length field

  localparam logic [31:0] PAD_MARKER = 32'h0000_0080;

  localparam logic [31:0] IV_A = 32'h6745_2301;
  localparam logic [31:0] IV_B = 32'hefcd_ab89;
  localparam logic [31:0] IV_C = 32'h98ba_dcfe;
  localparam logic [31:0] IV_D = 32'h1032_5476;

  // additive constant of each round
  localparam logic [31:0] ROUND_ADD [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
    32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
    32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
    32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
    32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
    32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
    32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
    32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
    32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // commands from the controller to the round unit
  typedef struct packed {
    logic start;   // load working words from the chain and run one block
    logic init;    // reload the chain with the initial values
  } md5_cmd_t;

  // status from the round unit back to the controller
  typedef struct packed {
    logic                  done;   // one-cycle pulse after the chain update
    logic [ADDR_W-1:0]     addr;   // message word wanted by the next round
    logic [4*32-1:0]       chain;  // {D, C, B, A}
  } md5_status_t;

  // message word order of each round group
  function automatic logic [ADDR_W-1:0] msg_index(input logic [5:0] r);
    logic [ADDR_W-1:0] k;
    logic [ADDR_W-1:0] idx;
    begin
      k = r[3:0];
      case (r[5:4])
        2'd0:    idx = k;
        2'd1:    idx = ADDR_W'((k << 2) + k + 4'd1);
        2'd2:    idx = ADDR_W'((k << 1) + k + 4'd5);
        default: idx = ADDR_W'((k << 3) - k);
      endcase
      return idx;
    end
  endfunction

  // left rotation per round
  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    begin
      case ({r[5:4], r[1:0]})
        4'b00_00: s = 5'd7;
        4'b00_01: s = 5'd12;
        4'b00_10: s = 5'd17;
        4'b00_11: s = 5'd22;
        4'b01_00: s = 5'd5;
        4'b01_01: s = 5'd9;
        4'b01_10: s = 5'd14;
        4'b01_11: s = 5'd20;
        4'b10_00: s = 5'd4;
        4'b10_01: s = 5'd11;
        4'b10_10: s = 5'd16;
        4'b10_11: s = 5'd23;
        4'b11_00: s = 5'd6;
        4'b11_01: s = 5'd10;
        4'b11_10: s = 5'd15;
        default:  s = 5'd21;
      endcase
      return s;
    end
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    begin
      w = {x, x} << s;
      return w[63:32];
    end
  endfunction

endpackage

[hw/rtl/md5_in_if.sv]
// md5_in_if: request channel carrying message words into the MD5 engine.
// Stand-alone; no package dependency.

interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, output data_word, output valid_bytes, output last_word,
                  input ready);
  modport sink   (input valid, input data_word, input valid_bytes, input last_word,
                  output ready);
endinterface

[hw/rtl/md5_out_if.sv]
// md5_out_if: request channel carrying a finished digest out of the MD5 engine.
// Stand-alone; no package dependency.

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  modport source (output valid, output digest_low, output digest_high, input ready);
  modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

[hw/rtl/md5_word_ram.sv]
// md5_word_ram: generic single-write, single-read synchronous RAM with registered read.
// No dependencies.

module md5_word_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/md5_round_unit.sv]
// md5_round_unit: iterative MD5 compression, one round per cycle, plus the chaining words.
// Depends on md5_pkg; message words arrive in the cycle after it presents their address.

module md5_round_unit (
  input  logic                clk,
  input  logic                rst,
  input  md5_pkg::md5_cmd_t   cmd,
  input  logic [31:0]         msg_word,
  output md5_pkg::md5_status_t status
);

  logic                          busy;
  logic                          done;
  logic [md5_pkg::CNT_W-1:0]     cnt;
  logic [31:0]                   a, b, c, d;
  logic [31:0]                   cv_a, cv_b, cv_c, cv_d;

  logic [5:0]  rnd;
  logic [31:0] f;
  logic [31:0] t;
  logic [31:0] b_next;
  logic        in_round;
  logic        last_step;

  // round of the word now arriving is one behind the issue count
  assign rnd       = 6'(cnt - 7'd1);
  assign in_round  = busy && (cnt != '0) && (cnt <= 7'(md5_pkg::ROUNDS));
  assign last_step = busy && (cnt == 7'(md5_pkg::ROUNDS + 1));

  // round function by group
  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  // two adds in parallel, then one, then the rotate and final add
  assign t      = (f + a) + (md5_pkg::ROUND_ADD[rnd] + msg_word);
  assign b_next = b + md5_pkg::rotl(t, md5_pkg::rot_amount(rnd));

  // sequencing and working words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      cv_a <= md5_pkg::IV_A;
      cv_b <= md5_pkg::IV_B;
      cv_c <= md5_pkg::IV_C;
      cv_d <= md5_pkg::IV_D;
    end else begin
      // pulse once the chain has taken the block
      done <= !cmd.start && last_step;
      if (cmd.init) begin
        cv_a <= md5_pkg::IV_A;
        cv_b <= md5_pkg::IV_B;
        cv_c <= md5_pkg::IV_C;
        cv_d <= md5_pkg::IV_D;
      end
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a    <= cv_a;
        b    <= cv_b;
        c    <= cv_c;
        d    <= cv_d;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (in_round) begin
          a <= d;
          d <= c;
          c <= b;
          b <= b_next;
        end
        if (last_step) begin
          cv_a <= cv_a + a;
          cv_b <= cv_b + b;
          cv_c <= cv_c + c;
          cv_d <= cv_d + d;
          busy <= 1'b0;
        end
      end
    end
  end

  assign status.done  = done;
  assign status.addr  = md5_pkg::msg_index(cnt[5:0]);
  assign status.chain = {cv_d, cv_c, cv_b, cv_a};

endmodule

[hw/rtl/md5_hash_engine.sv]
// md5_hash_engine: top level of the MD5 engine: input buffering, padding and digest output.
// Depends on md5_pkg, md5_in_if, md5_out_if, md5_word_ram and md5_round_unit.

// Message words are taken one per cycle into a 16-word block RAM until a block
// is full; the block is then compressed by a single round unit at one round per
// cycle, and no word is taken meanwhile. Compressing a block is a start step,
// the 64 rounds with the RAM read registered ahead of each round, and the
// chain update. A last item adds one or two padding blocks and a step to place
// the digest in the output register; the digest may wait there while the next
// message streams in. The length counter and chaining words return to their
// initial values after each digest, so messages follow one another without a
// gap.

module md5_hash_engine (
  input  logic       clk,
  input  logic       rst,
  md5_in_if.sink     in_chan,
  md5_out_if.source  out_chan
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BLOCK = 2'd1;
  localparam logic [1:0] ST_PAD   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                   state;
  logic [md5_pkg::ADDR_W-1:0]   fill;
  logic [63:0]                  bit_length;
  logic [31:0]                  pad_word;
  logic                         pad_extra;
  logic                         pad_two;
  logic                         pad_blk;
  logic [md5_pkg::ADDR_W-1:0]   word_sel;
  logic                         out_valid;
  logic [63:0]                  out_low;
  logic [63:0]                  out_high;

  md5_pkg::md5_cmd_t    cmd;
  md5_pkg::md5_status_t status;

  logic        in_accept;
  logic        slot_free;
  logic [2:0]  nb_clip;
  logic [31:0] pad_word_next;
  logic [6:0]  used_bytes;
  logic [31:0] ram_rdata;
  logic [31:0] msg_word;
  logic [4:0]  g_idx;
  logic [4:0]  fill_w;
  logic [4:0]  len_pos;
  logic        second_pad;

  assign in_accept     = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state == ST_IDLE);
  assign slot_free     = !out_valid || out_chan.ready;

  // last-item byte count clipped to four, marker placed after the valid bytes
  assign nb_clip = (in_chan.valid_bytes > 3'd4) ? 3'd4 : in_chan.valid_bytes;

  always_comb begin
    case (nb_clip)
      3'd0:    pad_word_next = md5_pkg::PAD_MARKER;
      3'd1:    pad_word_next = {16'h0, md5_pkg::PAD_MARKER[7:0], in_chan.data_word[7:0]};
      3'd2:    pad_word_next = {8'h0, md5_pkg::PAD_MARKER[7:0], in_chan.data_word[15:0]};
      3'd3:    pad_word_next = {md5_pkg::PAD_MARKER[7:0], in_chan.data_word[23:0]};
      default: pad_word_next = in_chan.data_word;
    endcase
  end

  assign used_bytes = {1'b0, fill, 2'b00} + {4'b0, nb_clip} + 7'd1;

  // a second padding block follows the first
  assign second_pad = (state == ST_PAD) && status.done && pad_two && !pad_blk;

  assign cmd.start = (in_accept && (in_chan.last_word || (fill == 4'(md5_pkg::BLOCK_WORDS - 1))))
                     || second_pad;
  assign cmd.init  = (state == ST_EMIT) && slot_free;

  // block buffer
  md5_word_ram #(
    .WIDTH (32),
    .DEPTH (md5_pkg::BLOCK_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (in_accept && !in_chan.last_word),
    .waddr (fill),
    .wdata (in_chan.data_word),
    .raddr (status.addr),
    .rdata (ram_rdata)
  );

  md5_round_unit u_rounds (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .msg_word (msg_word),
    .status   (status)
  );

  // word index is registered in step with the RAM read
  always_ff @(posedge clk) begin
    word_sel <= status.addr;
  end

  // message word source: buffer, or padding built on the fly
  assign g_idx   = {pad_blk, word_sel};
  assign fill_w  = {1'b0, fill};
  assign len_pos = pad_two ? 5'(md5_pkg::LEN_WORD + md5_pkg::BLOCK_WORDS)
                           : 5'(md5_pkg::LEN_WORD);

  always_comb begin
    if (state != ST_PAD) begin
      msg_word = ram_rdata;
    end else if (g_idx < fill_w) begin
      msg_word = ram_rdata;
    end else if (g_idx == fill_w) begin
      msg_word = pad_word;
    end else if (pad_extra && (g_idx == 5'(fill_w + 5'd1))) begin
      msg_word = md5_pkg::PAD_MARKER;
    end else if (g_idx == len_pos) begin
      msg_word = bit_length[31:0];
    end else if (g_idx == 5'(len_pos + 5'd1)) begin
      msg_word = bit_length[63:32];
    end else begin
      msg_word = '0;
    end
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      bit_length <= '0;
      pad_blk    <= 1'b0;
      pad_two    <= 1'b0;
      pad_extra  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // output register: loaded from the chain, freed when taken
      if ((state == ST_EMIT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (!in_chan.last_word) begin
              fill       <= fill + 4'd1;
              bit_length <= bit_length + 64'd32;
              if (fill == 4'(md5_pkg::BLOCK_WORDS - 1)) begin
                state <= ST_BLOCK;
              end
            end else begin
              bit_length <= bit_length + {58'b0, nb_clip, 3'b000};
              pad_word   <= pad_word_next;
              pad_extra  <= (nb_clip == 3'd4);
              pad_two    <= (used_bytes > 7'(md5_pkg::PAD_LIMIT));
              pad_blk    <= 1'b0;
              state      <= ST_PAD;
            end
          end
        end
        ST_BLOCK: begin
          if (status.done) begin
            state <= ST_IDLE;
          end
        end
        ST_PAD: begin
          if (second_pad) begin
            pad_blk <= 1'b1;
          end else if (status.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_low    <= status.chain[63:0];
            out_high   <= status.chain[127:64];
            bit_length <= '0;
            fill       <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid       = out_valid;
  assign out_chan.digest_low  = out_low;
  assign out_chan.digest_high = out_high;

endmodule
